@@ hw/rtl/bvp_pkg.sv @@
// shared widths, node class codes and data types for the boundary velocity projection
package bvp_pkg;

    // field widths
    localparam int VEL_W = 32;              // Q16.16 velocity
    localparam int VEC_W = 18;              // Q2.16 boundary vector
    localparam int CMP_W = VEC_W + 1;       // vector component after tangent negation
    localparam int PRD_W = VEL_W + CMP_W;   // v*c, 32 fraction bits
    localparam int SUM_W = PRD_W + 2;       // sum of three products
    localparam int DSH   = 8;               // dot product rounding shift
    localparam int DOT_W = SUM_W - DSH;     // dot product, 24 fraction bits
    localparam int SCL_W = DOT_W + CMP_W;   // dot*c, 40 fraction bits
    localparam int PSH   = 24;              // projection rounding shift
    localparam int PRJ_W = SCL_W - PSH;     // projected component, Q24.16
    localparam int RES_W = PRJ_W + 1;       // room for the face difference
    localparam int NCOMP = 3;

    // node class codes
    localparam logic [1:0] CLASS_INTERIOR = 2'd0;
    localparam logic [1:0] CLASS_FACE     = 2'd1;
    localparam logic [1:0] CLASS_EDGE     = 2'd2;
    localparam logic [1:0] CLASS_CORNER   = 2'd3;

    typedef logic signed [VEL_W-1:0] t_vel;
    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic signed [CMP_W-1:0] t_cmp;
    typedef logic signed [PRD_W-1:0] t_prd;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic signed [DOT_W-1:0] t_dot;
    typedef logic signed [SCL_W-1:0] t_scl;
    typedef logic signed [PRJ_W-1:0] t_prj;
    typedef logic signed [RES_W-1:0] t_res;

    // control that travels with each beat
    typedef struct packed {
        logic [1:0] cls;
        logic       three_d;
        logic       last;
    } t_ctl;

endpackage

@@ hw/rtl/boundary_velocity_projection.sv @@
// boundary velocity projection: four-stage pipeline, one mesh node per cycle
// results: an accepted node passes through the registered stages in order before its
//   result shows on o_valid (stages: products, dot, scale, output)
// throughput: one node every cycle; o_busy stays low, the pipeline never stalls
// reset: synchronous active-low i_rst_n clears all valid bits and sets 3D mode
// the receiver cannot stall: each result is shown for exactly one cycle
module boundary_velocity_projection (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [1:0]           i_node_class,
    input  bvp_pkg::t_vec        i_vec_x,
    input  bvp_pkg::t_vec        i_vec_y,
    input  bvp_pkg::t_vec        i_vec_z,
    input  bvp_pkg::t_vel        i_vel_in_x,
    input  bvp_pkg::t_vel        i_vel_in_y,
    input  bvp_pkg::t_vel        i_vel_in_z,
    input  logic                 i_last_node,
    output logic                 o_valid,
    output bvp_pkg::t_vel        o_vel_out_x,
    output bvp_pkg::t_vel        o_vel_out_y,
    output bvp_pkg::t_vel        o_vel_out_z,
    output logic                 o_clipped,
    output logic                 o_end_of_sweep
);
    import bvp_pkg::*;

    logic       r_three_d;
    logic [3:0] r_vld;

    t_ctl r_s1_ctl, r_s2_ctl, r_s3_ctl;
    t_vel r_s1_v [NCOMP];
    t_vel r_s2_v [NCOMP];
    t_vel r_s3_v [NCOMP];
    t_cmp r_s1_c [NCOMP];
    t_cmp r_s2_c [NCOMP];
    t_prd r_s1_p [NCOMP];
    t_dot r_s2_d;
    t_scl r_s3_s [NCOMP];

    t_vel r_out [NCOMP];
    logic r_clip;
    logic r_last;

    logic accept;
    t_vel n_v [NCOMP];
    t_cmp n_c [NCOMP];
    t_sum n_sum;
    t_vel n_out [NCOMP];
    logic n_clip;

    assign o_busy = 1'b0;
    assign accept = i_start & ~o_busy;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_three_d <= 1'b1;
        end else if (i_cfg_we) begin
            r_three_d <= i_cfg_wdata;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], accept};
        end
    end

    // select the projection vector: normal in 3D, tangent (ny,-nx) in 2D
    always_comb begin
        n_v[0] = i_vel_in_x;
        n_v[1] = i_vel_in_y;
        n_v[2] = i_vel_in_z;
        if (r_three_d) begin
            n_c[0] = CMP_W'(i_vec_x);
            n_c[1] = CMP_W'(i_vec_y);
            n_c[2] = CMP_W'(i_vec_z);
        end else begin
            n_c[0] = CMP_W'(i_vec_y);
            n_c[1] = -CMP_W'(i_vec_x);
            n_c[2] = '0;
        end
    end

    // stage 1: exact products v*c
    always_ff @(posedge i_clk) begin
        r_s1_ctl <= '{cls: i_node_class, three_d: r_three_d, last: i_last_node};
        for (int i = 0; i < NCOMP; i++) begin
            r_s1_v[i] <= n_v[i];
            r_s1_c[i] <= n_c[i];
            r_s1_p[i] <= PRD_W'(n_v[i]) * PRD_W'(n_c[i]);
        end
    end

    // stage 2: dot product rounded half up to 24 fraction bits
    always_comb begin
        n_sum = SUM_W'(r_s1_p[0]) + SUM_W'(r_s1_p[1]) + SUM_W'(r_s1_p[2])
              + (SUM_W'(1) <<< (DSH - 1));
    end

    always_ff @(posedge i_clk) begin
        r_s2_ctl <= r_s1_ctl;
        r_s2_v   <= r_s1_v;
        r_s2_c   <= r_s1_c;
        r_s2_d   <= n_sum[SUM_W-1:DSH];
    end

    // stage 3: scale the vector by the dot product
    always_ff @(posedge i_clk) begin
        r_s3_ctl <= r_s2_ctl;
        r_s3_v   <= r_s2_v;
        for (int i = 0; i < NCOMP; i++) begin
            r_s3_s[i] <= SCL_W'(r_s2_d) * SCL_W'(r_s2_c[i]);
        end
    end

    // stage 4: round, pick the rule per class and mode, saturate
    always_comb begin
        t_scl rnd;
        t_prj prj;
        t_res res;
        n_clip = 1'b0;
        for (int i = 0; i < NCOMP; i++) begin
            rnd = r_s3_s[i] + (SCL_W'(1) <<< (PSH - 1));
            prj = rnd[SCL_W-1:PSH];
            res = RES_W'(r_s3_v[i]);
            if (r_s3_ctl.three_d) begin
                case (r_s3_ctl.cls)
                    CLASS_CORNER: res = '0;
                    CLASS_EDGE:   res = RES_W'(prj);
                    CLASS_FACE:   res = RES_W'(r_s3_v[i]) - RES_W'(prj);
                    default:      res = RES_W'(r_s3_v[i]);
                endcase
            end else if (i != NCOMP - 1) begin
                case (r_s3_ctl.cls)
                    CLASS_CORNER: res = '0;
                    CLASS_FACE:   res = RES_W'(prj);
                    default:      res = RES_W'(r_s3_v[i]);
                endcase
            end
            // saturate when the upper bits are not a sign extension
            if ((&res[RES_W-1:VEL_W-1]) || !(|res[RES_W-1:VEL_W-1])) begin
                n_out[i] = res[VEL_W-1:0];
            end else begin
                n_clip   = 1'b1;
                n_out[i] = res[RES_W-1] ? {1'b1, {(VEL_W-1){1'b0}}}
                                        : {1'b0, {(VEL_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_clip <= n_clip;
        r_last <= r_s3_ctl.last;
    end

    assign o_valid        = r_vld[3];
    assign o_vel_out_x    = r_out[0];
    assign o_vel_out_y    = r_out[1];
    assign o_vel_out_z    = r_out[2];
    assign o_clipped      = r_clip;
    assign o_end_of_sweep = r_last;

`ifndef ASSERT_OFF
    // every accepted beat comes out as a result on o_valid
    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##4 o_valid)
        else $error("accepted beat produced no result");

    // no result without an earlier accepted beat
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 4))
        else $error("result without accepted beat");

    // a clipped result holds a component at a saturation limit
    a_clip_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |->
            (o_vel_out_x == {1'b0, {(VEL_W-1){1'b1}}} ||
             o_vel_out_x == {1'b1, {(VEL_W-1){1'b0}}} ||
             o_vel_out_y == {1'b0, {(VEL_W-1){1'b1}}} ||
             o_vel_out_y == {1'b1, {(VEL_W-1){1'b0}}} ||
             o_vel_out_z == {1'b0, {(VEL_W-1){1'b1}}} ||
             o_vel_out_z == {1'b1, {(VEL_W-1){1'b0}}}))
        else $error("clip flag without saturated component");
`endif

endmodule
